// ===== hdl/irdac_pkg.sv =====
package irdac_pkg;

  // Frame and field geometry
  localparam int FRAME_BITS = 32;
  localparam int BIT_CNT_W  = $clog2(FRAME_BITS + 1);
  localparam int SHIFT_W    = 32;
  localparam int CMD_W      = 16;
  localparam int STAMP_W    = 16;
  localparam int DUTY_W     = 16;
  localparam int GAIN_W     = 12;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // floor(x / 10) == (x * TENTH_RECIP) >> RECIP_SHIFT for every x below 2^22
  localparam int RECIP_SHIFT = 23;
  localparam int TENTH_RECIP = 838861;
  localparam int COEF_W      = 23;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MIN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MAX = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_FULL   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_BASE = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_GAIN = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_TOP  = 4'd7;

  // Register reset values
  localparam logic [15:0]       RST_LEADER_MIN = 16'd13500;
  localparam logic [15:0]       RST_LEADER_MAX = 16'd14500;
  localparam logic [15:0]       RST_ONE_MIN    = 16'd2250;
  localparam logic [15:0]       RST_ONE_MAX    = 16'd2450;
  localparam logic [DUTY_W-1:0] RST_PWM_FULL   = 16'd10000;
  localparam logic [15:0]       RST_SERVO_BASE = 16'd524;
  localparam logic [GAIN_W-1:0] RST_SERVO_GAIN = 12'd117;
  localparam logic [STEP_W-1:0] RST_SERVO_TOP  = 5'd18;

  // Remote command codes
  localparam logic [CMD_W-1:0] CMD_LED_ON     = 16'hBA45;
  localparam logic [CMD_W-1:0] CMD_LED_OFF    = 16'hB946;
  localparam logic [CMD_W-1:0] CMD_LED_TOGGLE = 16'hB847;
  localparam logic [CMD_W-1:0] CMD_DUTY_FULL  = 16'hBB44;
  localparam logic [CMD_W-1:0] CMD_DUTY_ZERO  = 16'hBF40;
  localparam logic [CMD_W-1:0] CMD_DUTY_INV   = 16'hBC43;
  localparam logic [CMD_W-1:0] CMD_STEP_DOWN  = 16'hF807;
  localparam logic [CMD_W-1:0] CMD_STEP_UP    = 16'hEA15;
  localparam logic [CMD_W-1:0] CMD_DUTY_10    = 16'hF609;
  localparam logic [CMD_W-1:0] CMD_DUTY_20    = 16'hE916;
  localparam logic [CMD_W-1:0] CMD_DUTY_30    = 16'hE619;
  localparam logic [CMD_W-1:0] CMD_DUTY_40    = 16'hF20D;
  localparam logic [CMD_W-1:0] CMD_DUTY_50    = 16'hE718;
  localparam logic [CMD_W-1:0] CMD_DUTY_60    = 16'hF708;
  localparam logic [CMD_W-1:0] CMD_DUTY_70    = 16'hE31C;
  localparam logic [CMD_W-1:0] CMD_DUTY_80    = 16'hA55A;
  localparam logic [CMD_W-1:0] CMD_DUTY_90    = 16'hAD52;

  // Decoder phase
  typedef enum logic [3:0] {
    PH_FIRST  = 4'b0001,
    PH_SECOND = 4'b0010,
    PH_SKIP   = 4'b0100,
    PH_BITS   = 4'b1000
  } irdac_phase_t;

  typedef struct packed {
    logic [15:0]       leader_min;
    logic [15:0]       leader_max;
    logic [15:0]       one_min;
    logic [15:0]       one_max;
    logic [DUTY_W-1:0] pwm_full;
    logic [15:0]       servo_base;
    logic [GAIN_W-1:0] servo_gain;
    logic [STEP_W-1:0] servo_top;
  } irdac_cfg_t;

  // Frame completion for the edge being processed
  typedef struct packed {
    logic             done;
    logic [CMD_W-1:0] command;
  } irdac_frame_t;

endpackage

// ===== hdl/irdac_edge_if.sv =====
interface irdac_edge_if import irdac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [STAMP_W-1:0] stamp;

  modport source (output valid, output kind, output stamp, input ready);
  modport sink (input valid, input kind, input stamp, output ready);
endinterface

// ===== hdl/irdac_result_if.sv =====
interface irdac_result_if import irdac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_done;
  logic [CMD_W-1:0]  command;
  logic              led_on;
  logic [DUTY_W-1:0] pwm_duty;
  logic [STEP_W-1:0] servo_pos;
  logic [15:0]       servo_compare;

  modport source (output valid, output frame_done, output command, output led_on,
                  output pwm_duty, output servo_pos, output servo_compare, input ready);
  modport sink (input valid, input frame_done, input command, input led_on,
                input pwm_duty, input servo_pos, input servo_compare, output ready);
endinterface

// ===== hdl/irdac_cfg_if.sv =====
interface irdac_cfg_if import irdac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/irdac_cfg.sv =====
module irdac_cfg import irdac_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output logic                  wr_ready,
  output irdac_cfg_t            cfg
);

  // Always take a write
  assign wr_ready = 1'b1;

  // Update the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_min <= RST_LEADER_MIN;
      cfg.leader_max <= RST_LEADER_MAX;
      cfg.one_min    <= RST_ONE_MIN;
      cfg.one_max    <= RST_ONE_MAX;
      cfg.pwm_full   <= RST_PWM_FULL;
      cfg.servo_base <= RST_SERVO_BASE;
      cfg.servo_gain <= RST_SERVO_GAIN;
      cfg.servo_top  <= RST_SERVO_TOP;
    end else if (wr_valid) begin
      case (wr_index)
        REG_LEADER_MIN: cfg.leader_min <= wr_data;
        REG_LEADER_MAX: cfg.leader_max <= wr_data;
        REG_ONE_MIN:    cfg.one_min    <= wr_data;
        REG_ONE_MAX:    cfg.one_max    <= wr_data;
        REG_PWM_FULL:   cfg.pwm_full   <= wr_data;
        REG_SERVO_BASE: cfg.servo_base <= wr_data;
        REG_SERVO_GAIN: cfg.servo_gain <= wr_data[GAIN_W-1:0];
        REG_SERVO_TOP:  cfg.servo_top  <= wr_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/irdac_frame.sv =====
module irdac_frame import irdac_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               kind,
  input  logic [STAMP_W-1:0] stamp,
  input  irdac_cfg_t         cfg,
  output irdac_frame_t       frame,
  output logic [CMD_W-1:0]   last_command
);

  irdac_phase_t         phase, phase_next;
  logic [STAMP_W-1:0]   last_stamp, last_stamp_next;
  logic [BIT_CNT_W-1:0] bits_taken, bits_taken_next;
  logic [SHIFT_W-1:0]   frame_shift, frame_shift_next;
  logic [CMD_W-1:0]     last_command_next;
  logic [STAMP_W-1:0]   gap;
  logic                 leader_ok;
  logic                 one_bit;
  logic                 done;

  // Wrapped interval to the previous used edge
  assign gap       = stamp - last_stamp;
  assign leader_ok = (gap > cfg.leader_min) && (gap < cfg.leader_max);
  assign one_bit   = (gap > cfg.one_min) && (gap < cfg.one_max);

  // Walk the leader, skip edge and data bits; wrong polarity is ignored
  always_comb begin
    phase_next       = phase;
    last_stamp_next  = last_stamp;
    bits_taken_next  = bits_taken;
    frame_shift_next = frame_shift;
    done             = 1'b0;
    case (phase)
      PH_FIRST: begin
        if (!kind) begin
          last_stamp_next = stamp;
          phase_next      = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (!kind) begin
          last_stamp_next = stamp;
          phase_next      = leader_ok ? PH_SKIP : PH_FIRST;
        end
      end
      PH_SKIP: begin
        if (kind) begin
          last_stamp_next = stamp;
          bits_taken_next = '0;
          phase_next      = PH_BITS;
        end
      end
      PH_BITS: begin
        if (kind) begin
          last_stamp_next  = stamp;
          frame_shift_next = {one_bit, frame_shift[SHIFT_W-1:1]};
          if (bits_taken == BIT_CNT_W'(FRAME_BITS - 1)) begin
            bits_taken_next = '0;
            phase_next      = PH_FIRST;
            done            = 1'b1;
          end else begin
            bits_taken_next = bits_taken + 1'b1;
          end
        end
      end
      default: phase_next = PH_FIRST;
    endcase
  end

  assign last_command_next = done ? frame_shift_next[SHIFT_W-1 -: CMD_W] : last_command;
  assign frame.done        = done;
  assign frame.command     = last_command_next;

  // Advance decoder state on each processed edge
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FIRST;
      last_stamp   <= '0;
      bits_taken   <= '0;
      frame_shift  <= '0;
      last_command <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      last_stamp   <= last_stamp_next;
      bits_taken   <= bits_taken_next;
      frame_shift  <= frame_shift_next;
      last_command <= last_command_next;
    end
  end

endmodule

// ===== hdl/irdac_act.sv =====
module irdac_act import irdac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  irdac_frame_t      frame,
  input  irdac_cfg_t        cfg,
  output logic              led_on,
  output logic [DUTY_W-1:0] pwm_duty,
  output logic [STEP_W-1:0] servo_pos,
  output logic [15:0]       servo_compare
);

  localparam int PROD_W = DUTY_W + COEF_W;
  localparam int CMP_W  = 18;

  logic                led, led_next;
  logic [DUTY_W-1:0]   duty, duty_next;
  logic [STEP_W-1:0]   pos, pos_next;
  logic [COEF_W-1:0]   coef;
  logic [PROD_W-1:0]   pct_prod;
  logic [DUTY_W-1:0]   pct;
  logic [STEP_W:0]     step_inc;
  logic [CMP_W-1:0]    cmp_sum;

  // Pick the tenths coefficient for the percentage commands
  always_comb begin
    case (frame.command)
      CMD_DUTY_10: coef = COEF_W'(TENTH_RECIP * 1);
      CMD_DUTY_20: coef = COEF_W'(TENTH_RECIP * 2);
      CMD_DUTY_30: coef = COEF_W'(TENTH_RECIP * 3);
      CMD_DUTY_40: coef = COEF_W'(TENTH_RECIP * 4);
      CMD_DUTY_50: coef = COEF_W'(TENTH_RECIP * 5);
      CMD_DUTY_60: coef = COEF_W'(TENTH_RECIP * 6);
      CMD_DUTY_70: coef = COEF_W'(TENTH_RECIP * 7);
      CMD_DUTY_80: coef = COEF_W'(TENTH_RECIP * 8);
      CMD_DUTY_90: coef = COEF_W'(TENTH_RECIP * 9);
      default:     coef = '0;
    endcase
  end

  // floor(pwm_full * k / 10) through one reciprocal multiply
  assign pct_prod = PROD_W'(cfg.pwm_full) * PROD_W'(coef);
  assign pct      = pct_prod[RECIP_SHIFT +: DUTY_W];
  assign step_inc = {1'b0, pos} + 1'b1;

  // Run the command of a completed frame
  always_comb begin
    led_next  = led;
    duty_next = duty;
    pos_next  = pos;
    if (frame.done) begin
      case (frame.command)
        CMD_LED_ON:     led_next  = 1'b1;
        CMD_LED_OFF:    led_next  = 1'b0;
        CMD_LED_TOGGLE: led_next  = ~led;
        CMD_DUTY_FULL:  duty_next = cfg.pwm_full;
        CMD_DUTY_ZERO:  duty_next = '0;
        CMD_DUTY_INV:   duty_next = (duty > cfg.pwm_full) ? '0 : cfg.pwm_full - duty;
        CMD_STEP_DOWN:  pos_next  = (pos != '0) ? pos - 1'b1 : pos;
        CMD_STEP_UP: begin
          duty_next = '0;
          pos_next  = (step_inc > {1'b0, cfg.servo_top}) ? cfg.servo_top
                                                         : step_inc[STEP_W-1:0];
        end
        CMD_DUTY_10: duty_next = pct;
        CMD_DUTY_20: begin
          duty_next = pct;
          pos_next  = '0;
        end
        CMD_DUTY_30: begin
          duty_next = pct;
          pos_next  = cfg.servo_top >> 1;
        end
        CMD_DUTY_40: begin
          duty_next = pct;
          pos_next  = cfg.servo_top;
        end
        CMD_DUTY_50: duty_next = pct;
        CMD_DUTY_60: duty_next = pct;
        CMD_DUTY_70: duty_next = pct;
        CMD_DUTY_80: duty_next = pct;
        CMD_DUTY_90: duty_next = pct;
        default: ;
      endcase
    end
  end

  // Hold actuator state between processed edges
  always_ff @(posedge clk) begin
    if (rst) begin
      led  <= 1'b0;
      duty <= RST_PWM_FULL;
      pos  <= '0;
    end else if (advance) begin
      led  <= led_next;
      duty <= duty_next;
      pos  <= pos_next;
    end
  end

  // Servo compare from the held step, saturated to 16 bits
  assign cmp_sum       = CMP_W'(cfg.servo_base) + CMP_W'(pos) * CMP_W'(cfg.servo_gain);
  assign servo_compare = (|cmp_sum[CMP_W-1:16]) ? 16'hFFFF : cmp_sum[15:0];

  assign led_on    = led;
  assign pwm_duty  = duty;
  assign servo_pos = pos;

endmodule

// ===== hdl/ir_remote_decoder_actuator_control_core.sv =====
// IR remote decoder with LED, PWM and servo control. Each transfer on edges is one
// receiver edge (kind 0 falling, 1 rising) with its 16-bit tick stamp; every edge
// yields exactly one transfer on results carrying the frame-done flag, the last
// decoded command and the current LED level, PWM duty, servo step and servo compare.
// An edge is registered on entry and processed into the decoder and actuator state
// once the result stage can take it; one edge is accepted per clock unless stalled,
// and the single result stage stalls the input only while a result waits to be taken.
// Configuration writes (indexes 0 to 7, higher ones are ignored) are always accepted
// and must be issued only while no edge is in flight.
module ir_remote_decoder_actuator_control_core import irdac_pkg::*; (
  input logic           clk,
  input logic           rst,
  irdac_edge_if.sink    edges,
  irdac_result_if.source results,
  irdac_cfg_if.sink     cfg
);

  irdac_cfg_t         cfg_regs;
  irdac_frame_t       frame;
  logic               in_valid;
  logic               in_kind;
  logic [STAMP_W-1:0] in_stamp;
  logic               out_valid;
  logic               done;
  logic               advance;

  // Move the registered edge on when the result stage is free or draining
  assign advance     = in_valid && (!out_valid || results.ready);
  assign edges.ready = !in_valid || advance;

  irdac_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .wr_ready (cfg.ready),
    .cfg      (cfg_regs)
  );

  // Capture the incoming edge
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (edges.ready) begin
      in_valid <= edges.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (edges.valid && edges.ready) begin
      in_kind  <= edges.kind;
      in_stamp <= edges.stamp;
    end
  end

  irdac_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .kind         (in_kind),
    .stamp        (in_stamp),
    .cfg          (cfg_regs),
    .frame        (frame),
    .last_command (results.command)
  );

  irdac_act u_act (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .frame         (frame),
    .cfg           (cfg_regs),
    .led_on        (results.led_on),
    .pwm_duty      (results.pwm_duty),
    .servo_pos     (results.servo_pos),
    .servo_compare (results.servo_compare)
  );

  // Result stage: state registers hold the fields, add valid and frame-done
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      done <= frame.done;
    end
  end

  assign results.valid      = out_valid;
  assign results.frame_done = done;

endmodule

// ===== bench/irdac_status_checker.sv =====
// Watches the edge, result and register channels, runs a cycle-free model of
// the decoder on every accepted edge and compares each result against it.
module irdac_status_checker import irdac_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  irdac_edge_if   edges,
  irdac_result_if results,
  irdac_cfg_if    cfg,
  output int      fails,
  output int      pending,
  output int      frames_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              done;
    logic [CMD_W-1:0]  command;
    logic              led;
    logic [DUTY_W-1:0] duty;
    logic [STEP_W-1:0] pos;
    logic [15:0]       compare;
  } status_t;

  // Model state and register copy
  irdac_cfg_t          regs;
  irdac_phase_t        phase;
  logic [STAMP_W-1:0]  prev_stamp;
  logic [5:0]          bit_count;
  logic [SHIFT_W-1:0]  frame_word;
  logic [CMD_W-1:0]    cmd_reg;
  logic                led_level;
  logic [DUTY_W-1:0]   duty;
  logic [STEP_W-1:0]   pos;

  status_t status_q [$];
  int      mismatches;

  initial begin
    fails       = 0;
    pending     = 0;
    frames_seen = 0;
    mismatches  = 0;
  end

  function automatic logic [DUTY_W-1:0] duty_tenths(input int tenths);
    int full;
    full = regs.pwm_full;
    return DUTY_W'((full * tenths) / 10);
  endfunction

  task automatic run_command(input logic [CMD_W-1:0] code);
    int nxt;
    case (code)
      CMD_LED_ON:     led_level = 1'b1;
      CMD_LED_OFF:    led_level = 1'b0;
      CMD_LED_TOGGLE: led_level = ~led_level;
      CMD_DUTY_FULL:  duty = regs.pwm_full;
      CMD_DUTY_ZERO:  duty = '0;
      CMD_DUTY_INV:   duty = (duty > regs.pwm_full) ? '0 : regs.pwm_full - duty;
      CMD_STEP_DOWN: begin
        if (pos != '0) pos = pos - 1'b1;
      end
      CMD_STEP_UP: begin
        duty = '0;
        nxt  = int'(pos) + 1;
        pos  = (nxt > int'(regs.servo_top)) ? regs.servo_top : STEP_W'(nxt);
      end
      CMD_DUTY_10: duty = duty_tenths(1);
      CMD_DUTY_20: begin
        duty = duty_tenths(2);
        pos  = '0;
      end
      CMD_DUTY_30: begin
        duty = duty_tenths(3);
        pos  = regs.servo_top >> 1;
      end
      CMD_DUTY_40: begin
        duty = duty_tenths(4);
        pos  = regs.servo_top;
      end
      CMD_DUTY_50: duty = duty_tenths(5);
      CMD_DUTY_60: duty = duty_tenths(6);
      CMD_DUTY_70: duty = duty_tenths(7);
      CMD_DUTY_80: duty = duty_tenths(8);
      CMD_DUTY_90: duty = duty_tenths(9);
      default: ;
    endcase
  endtask

  // Advance the decoder by one edge and return the status it reports
  task automatic decode_edge(input logic rising, input logic [STAMP_W-1:0] stamp,
                             output status_t st);
    logic [STAMP_W-1:0] gap;
    logic               done;
    int                 cmp;
    gap  = stamp - prev_stamp;
    done = 1'b0;
    case (phase)
      PH_FIRST: begin
        if (!rising) begin
          prev_stamp = stamp;
          phase      = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (!rising) begin
          prev_stamp = stamp;
          phase = (gap > regs.leader_min && gap < regs.leader_max) ? PH_SKIP : PH_FIRST;
        end
      end
      PH_SKIP: begin
        if (rising) begin
          prev_stamp = stamp;
          bit_count  = '0;
          phase      = PH_BITS;
        end
      end
      default: begin
        if (rising) begin
          prev_stamp = stamp;
          frame_word = {(gap > regs.one_min && gap < regs.one_max), frame_word[SHIFT_W-1:1]};
          bit_count  = bit_count + 1'b1;
          if (bit_count >= FRAME_BITS) begin
            bit_count = '0;
            phase     = PH_FIRST;
            cmd_reg   = frame_word[SHIFT_W-1 -: CMD_W];
            done      = 1'b1;
            run_command(cmd_reg);
          end
        end
      end
    endcase
    cmp = int'(regs.servo_base) + int'(pos) * int'(regs.servo_gain);
    if (cmp > 65535) cmp = 65535;
    st.done    = done;
    st.command = cmd_reg;
    st.led     = led_level;
    st.duty    = duty;
    st.pos     = pos;
    st.compare = cmp[15:0];
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      fails++;
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      regs.leader_min = RST_LEADER_MIN;
      regs.leader_max = RST_LEADER_MAX;
      regs.one_min    = RST_ONE_MIN;
      regs.one_max    = RST_ONE_MAX;
      regs.pwm_full   = RST_PWM_FULL;
      regs.servo_base = RST_SERVO_BASE;
      regs.servo_gain = RST_SERVO_GAIN;
      regs.servo_top  = RST_SERVO_TOP;
      phase      = PH_FIRST;
      prev_stamp = '0;
      bit_count  = '0;
      frame_word = '0;
      cmd_reg    = '0;
      led_level  = 1'b0;
      duty       = RST_PWM_FULL;
      pos        = '0;
      status_q.delete();
    end else begin
      // Register writes land in the model copy
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LEADER_MIN: regs.leader_min = cfg.data;
          REG_LEADER_MAX: regs.leader_max = cfg.data;
          REG_ONE_MIN:    regs.one_min    = cfg.data;
          REG_ONE_MAX:    regs.one_max    = cfg.data;
          REG_PWM_FULL:   regs.pwm_full   = cfg.data;
          REG_SERVO_BASE: regs.servo_base = cfg.data;
          REG_SERVO_GAIN: regs.servo_gain = cfg.data[GAIN_W-1:0];
          REG_SERVO_TOP:  regs.servo_top  = cfg.data[STEP_W-1:0];
          default: ;
        endcase
      end
      // Compare a result transfer against the oldest expectation
      if (results.valid && results.ready) begin
        if (results.frame_done === 1'b1) frames_seen++;
        if (status_q.size() == 0) begin
          fails++;
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with nothing expected", $realtime);
        end else begin
          want = status_q.pop_front();
          check_field("frame_done", 16'(want.done), 16'(results.frame_done));
          check_field("command", want.command, results.command);
          check_field("led_on", 16'(want.led), 16'(results.led_on));
          check_field("pwm_duty", want.duty, results.pwm_duty);
          check_field("servo_pos", 16'(want.pos), 16'(results.servo_pos));
          check_field("servo_compare", want.compare, results.servo_compare);
        end
      end
      // Predict the status for each edge transfer
      if (edges.valid && edges.ready) begin
        decode_edge(edges.kind, edges.stamp, want);
        status_q.push_back(want);
      end
    end
    pending = status_q.size();
  end

endmodule

// ===== bench/tb_ir_remote_decoder_actuator_control_core.sv =====
module tb_ir_remote_decoder_actuator_control_core;
  import irdac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 90;
  localparam int PHASE_EDGES = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;

  logic clk;
  logic rst;

  irdac_edge_if   edge_ch ();
  irdac_result_if result_ch ();
  irdac_cfg_if    cfg_ch ();

  int fails;
  int pending;
  int frames_seen;

  // Stimulus bookkeeping
  logic [STAMP_W-1:0] tick;
  int lead_lo, lead_hi, one_lo, one_hi;
  int edges_sent;
  int reg_writes;
  int settings_used;
  int hold_requests;
  int cycle_count;
  bit no_idle;
  logic [CMD_W-1:0] codes [17];

  ir_remote_decoder_actuator_control_core DUT (
    .clk     (clk),
    .rst     (rst),
    .edges   (edge_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  irdac_status_checker status_check (
    .clk         (clk),
    .rst         (rst),
    .edges       (edge_ch),
    .results     (result_ch),
    .cfg         (cfg_ch),
    .fails       (fails),
    .pending     (pending),
    .frames_seen (frames_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result side: random back-pressure plus long holds on request
  initial begin : result_sink
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= no_idle || ($urandom_range(99) >= 7);
      end
    end
  end

  function automatic int gap_inside(input int lo, input int hi);
    return $urandom_range(hi - 1, lo + 1);
  endfunction

  // Boundaries count as outside the exclusive window
  function automatic int gap_outside(input int lo, input int hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      2: return $urandom_range(lo, 0);
      default: return $urandom_range(65535, hi);
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] random_command();
    if ($urandom_range(4) == 0) return CMD_W'($urandom_range(65535));
    return codes[$urandom_range(16)];
  endfunction

  // Offer one edge, idling now and then, and hold it until the transfer
  task automatic push_edge(input logic rising, input logic [STAMP_W-1:0] stamp);
    while (!no_idle && $urandom_range(99) < 7) begin
      edge_ch.valid <= 1'b0;
      edge_ch.kind  <= 1'($urandom_range(1));
      edge_ch.stamp <= STAMP_W'($urandom_range(65535));
      @(posedge clk);
    end
    edge_ch.valid <= 1'b1;
    edge_ch.kind  <= rising;
    edge_ch.stamp <= stamp;
    do @(posedge clk); while (edge_ch.ready !== 1'b1);
    edges_sent++;
  endtask

  task automatic advance(input logic rising, input int gap);
    tick = tick + STAMP_W'(gap);
    push_edge(rising, tick);
  endtask

  task automatic send_leader();
    advance(1'b0, $urandom_range(20000, 100));
    advance(1'b0, gap_inside(lead_lo, lead_hi));
  endtask

  task automatic send_frame(input logic [CMD_W-1:0] cmd, input bit noisy);
    logic [SHIFT_W-1:0] word;
    int i;
    word = {cmd, 16'($urandom_range(65535))};
    send_leader();
    if (noisy) push_edge(1'b0, STAMP_W'($urandom_range(65535)));
    advance(1'b1, $urandom_range(65535));
    for (i = 0; i < FRAME_BITS; i++) begin
      // Falling edges between bits are ignored by the decoder
      if (noisy && $urandom_range(3) == 0) push_edge(1'b0, STAMP_W'($urandom_range(65535)));
      advance(1'b1, word[i] ? gap_inside(one_lo, one_hi) : gap_outside(one_lo, one_hi));
    end
  endtask

  // Enough rising edges to finish any partial frame
  task automatic flush_frame();
    repeat (FRAME_BITS + 8) advance(1'b1, $urandom_range(65535));
  endtask

  task automatic random_traffic(input int count);
    int target;
    int pick;
    target = edges_sent + count;
    while (edges_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(random_command(), $urandom_range(1));
      end else if (pick < 80) begin
        advance(1'b0, $urandom_range(65535));
        advance(1'b0, gap_outside(lead_lo, lead_hi));
      end else if (pick < 90) begin
        // Frame cut short
        send_leader();
        advance(1'b1, $urandom_range(65535));
        repeat ($urandom_range(FRAME_BITS - 1, 1)) advance(1'b1, $urandom_range(65535));
        flush_frame();
      end else begin
        repeat ($urandom_range(24, 8))
          push_edge(1'($urandom_range(1)), STAMP_W'($urandom_range(65535)));
        flush_frame();
      end
    end
  endtask

  // Drop valid and wait until every expected status has arrived
  task automatic settle();
    edge_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    reg_writes++;
  endtask

  task automatic configure(input int lmin, input int lmax, input int omin, input int omax,
                           input int full, input int base, input int gain, input int top);
    settle();
    write_reg(REG_LEADER_MIN, lmin);
    write_reg(REG_LEADER_MAX, lmax);
    write_reg(REG_ONE_MIN, omin);
    write_reg(REG_ONE_MAX, omax);
    write_reg(REG_PWM_FULL, full);
    write_reg(REG_SERVO_BASE, base);
    write_reg(REG_SERVO_GAIN, gain);
    write_reg(REG_SERVO_TOP, top);
    // Unused index must leave every register alone
    write_reg(REG_SPARE, $urandom_range(65535));
    cfg_ch.valid <= 1'b0;
    lead_lo = lmin;
    lead_hi = lmax;
    one_lo  = omin;
    one_hi  = omax;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [CMD_W-1:0] walk [$];
    int i;
    int lmin, omin;
    codes = '{CMD_LED_ON, CMD_LED_OFF, CMD_LED_TOGGLE, CMD_DUTY_FULL, CMD_DUTY_ZERO,
              CMD_DUTY_INV, CMD_STEP_DOWN, CMD_STEP_UP, CMD_DUTY_10, CMD_DUTY_20,
              CMD_DUTY_30, CMD_DUTY_40, CMD_DUTY_50, CMD_DUTY_60, CMD_DUTY_70,
              CMD_DUTY_80, CMD_DUTY_90};
    edges_sent    = 0;
    reg_writes    = 0;
    settings_used = 1;
    hold_requests = 0;
    no_idle       = 1'b0;
    tick          = '0;
    lead_lo = RST_LEADER_MIN;
    lead_hi = RST_LEADER_MAX;
    one_lo  = RST_ONE_MIN;
    one_hi  = RST_ONE_MAX;
    rst           <= 1'b1;
    edge_ch.valid <= 1'b0;
    edge_ch.kind  <= 1'b0;
    edge_ch.stamp <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rising edge while a falling one is awaited, then leaders on both bounds
    push_edge(1'b1, STAMP_W'($urandom_range(65535)));
    advance(1'b0, 500);
    advance(1'b0, lead_lo);
    advance(1'b0, 500);
    advance(1'b0, lead_hi);

    // Servo step driven into saturation at both ends
    walk = '{CMD_DUTY_20, CMD_STEP_DOWN, CMD_DUTY_40, CMD_STEP_UP};
    for (i = 0; i < walk.size(); i++) send_frame(walk[i], i[0]);

    // Reset values written back, no idling on either side
    configure(RST_LEADER_MIN, RST_LEADER_MAX, RST_ONE_MIN, RST_ONE_MAX,
              RST_PWM_FULL, RST_SERVO_BASE, RST_SERVO_GAIN, RST_SERVO_TOP);
    no_idle = 1'b1;
    random_traffic(PHASE_EDGES);
    no_idle = 1'b0;

    // Widest windows, largest scales; compare value saturates
    configure(0, 65535, 0, 65535, 65535, 65535, 4095, 31);
    send_frame(CMD_DUTY_40, 1'b0);
    hold_requests++;
    random_traffic(PHASE_EDGES);

    // Narrowest windows, zero scales; inverting a duty above full gives zero
    configure(65533, 65535, 65532, 65535, 0, 0, 0, 0);
    send_frame(CMD_DUTY_INV, 1'b0);
    random_traffic(PHASE_EDGES);

    // Two random settings, each under a long result hold
    repeat (2) begin
      lmin = $urandom_range(60000);
      omin = $urandom_range(60000);
      configure(lmin, lmin + $urandom_range(3000, 2), omin, omin + $urandom_range(3000, 2),
                $urandom_range(65535), $urandom_range(65535), $urandom_range(4095),
                $urandom_range(31));
      hold_requests++;
      random_traffic(PHASE_EDGES);
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Drove %0d edges yielding %0d decoded frames across %0d register settings",
             edges_sent, frames_seen, settings_used);
    $display("(%0d register writes, long result holds and idle-free stretches included)",
             reg_writes);
    if (fails == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
